@@ src/ttw_pkg.sv @@
// Shared constants, types and codes of the text terminal writer.
package ttw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int PTR_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam int CELL_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int OPCODE_W   = 2;
  localparam int IDX_W      = 11;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int CMP_W      = (IDX_W > PTR_W) ? IDX_W : PTR_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  // Word index of the text color register on the configuration port.
  localparam logic CFG_TEXT_COLOR = 1'b0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ src/ttw_screen_ram.sv @@
// Screen cell store: one write port and one registered read port.
module ttw_screen_ram (
  input  logic                        clk,
  input  ttw_pkg::ram_req_t           req,
  output logic [ttw_pkg::CELL_W-1:0]  rdata
);

  logic [ttw_pkg::CELL_W-1:0] mem [ttw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ src/ttw_cfg_regs.sv @@
// APB-style configuration register file holding the text color.
module ttw_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ttw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ttw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ttw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [ttw_pkg::ATTR_W-1:0]      text_color
);

  logic [ttw_pkg::ATTR_W-1:0] text_color_r;
  logic [ttw_pkg::ATTR_W-1:0] text_color_nxt;
  logic                       hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == ttw_pkg::CFG_TEXT_COLOR);

  always_comb begin
    text_color_nxt = text_color_r;
    if (psel && penable && pwrite && pready && hit) begin
      text_color_nxt = pwdata[ttw_pkg::ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= ttw_pkg::RESET_ATTR;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  assign prdata = hit ? ttw_pkg::CFG_DATA_W'(text_color_r) : '0;
  assign text_color = text_color_r;

endmodule

@@ src/text_terminal_writer_unit.sv @@
// Top level of the text terminal writer: command sequencer around the screen store.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | opcode, char_code, cell_index
//   out     | output    | out_valid/out_ready | cell_word, cursor_row, cursor_col, did_scroll
//   cfg     | input     | psel/penable/pready | text_color at word 0
//
// A put or newline that does not scroll and the unused opcode go straight to the done
// state; a cell read passes through the read state first, unless past the last cell.
// A scroll copies one cell per cycle through the store's read and write ports, then
// blanks the bottom row. Clear writes one cell per cycle.
// After reset a pass fills the store with blanks before the first beat is taken;
// configuration writes are taken meanwhile.
// A result waiting at the output holds back only the completion of the next item.
module text_terminal_writer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ttw_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [ttw_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [ttw_pkg::IDX_W-1:0]         in_cell_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ttw_pkg::CELL_W-1:0]        out_cell_word,
  output logic [ttw_pkg::ROW_OUT_W-1:0]     out_cursor_row,
  output logic [ttw_pkg::COL_OUT_W-1:0]     out_cursor_col,
  output logic                              out_did_scroll,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ttw_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ttw_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ttw_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam logic [ttw_pkg::ROW_W-1:0]  ROW_LAST  = ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1);
  localparam logic [ttw_pkg::COL_W-1:0]  COL_LAST  = ttw_pkg::COL_W'(ttw_pkg::COLUMNS - 1);
  localparam logic [ttw_pkg::ADDR_W-1:0] ADDR_LAST =
    ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT - 1);
  localparam logic [ttw_pkg::ADDR_W-1:0] LAST_ROW_BASE =
    ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT - ttw_pkg::COLUMNS);
  localparam logic [ttw_pkg::PTR_W-1:0]  PTR_CELLS = ttw_pkg::PTR_W'(ttw_pkg::CELL_COUNT);
  localparam logic [ttw_pkg::PTR_W-1:0]  PTR_COLS  = ttw_pkg::PTR_W'(ttw_pkg::COLUMNS);

  ttw_pkg::state_t state_r, state_nxt;

  logic [ttw_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [ttw_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [ttw_pkg::PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic                          copy_pend_r, copy_pend_nxt;
  logic [ttw_pkg::ADDR_W-1:0]    copy_wa_r, copy_wa_nxt;
  logic [ttw_pkg::ADDR_W-1:0]    fill_ptr_r, fill_ptr_nxt;
  logic [ttw_pkg::CELL_W-1:0]    res_word_r, res_word_nxt;
  logic                          res_scroll_r, res_scroll_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [ttw_pkg::CELL_W-1:0]    out_word_r;
  logic [ttw_pkg::ROW_OUT_W-1:0] out_row_r;
  logic [ttw_pkg::COL_OUT_W-1:0] out_col_r;
  logic                          out_scroll_r;
  logic                          out_load;

  ttw_pkg::ram_req_t             ram_req;
  logic [ttw_pkg::CELL_W-1:0]    ram_rdata;
  logic [ttw_pkg::ATTR_W-1:0]    text_color;
  logic [ttw_pkg::ADDR_W-1:0]    cursor_addr;
  logic                          idx_in_range;
  logic                          wrap;

  ttw_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .text_color (text_color)
  );

  ttw_screen_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign cursor_addr  = ttw_pkg::ADDR_W'(ttw_pkg::ADDR_W'(row_r) *
                        ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS)) + ttw_pkg::ADDR_W'(col_r);
  assign idx_in_range = ttw_pkg::CMP_W'(in_cell_index) <
                        ttw_pkg::CMP_W'(ttw_pkg::CELL_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    rd_ptr_nxt     = rd_ptr_r;
    copy_pend_nxt  = copy_pend_r;
    copy_wa_nxt    = copy_wa_r;
    fill_ptr_nxt   = fill_ptr_r;
    res_word_nxt   = res_word_r;
    res_scroll_nxt = res_scroll_r;
    ram_req        = '0;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    wrap           = 1'b0;

    unique case (state_r)
      ttw_pkg::ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = fill_ptr_r;
        ram_req.wdata = {ttw_pkg::RESET_ATTR, ttw_pkg::BLANK_CHAR};
        fill_ptr_nxt  = fill_ptr_r + 1'b1;
        if (fill_ptr_r == ADDR_LAST) begin
          state_nxt = ttw_pkg::ST_IDLE;
        end
      end

      ttw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_word_nxt   = '0;
          res_scroll_nxt = 1'b0;
          unique case (ttw_pkg::op_t'(in_opcode))
            ttw_pkg::OP_PUT: begin
              if (in_char_code == ttw_pkg::NEWLINE_CODE) begin
                wrap = 1'b1;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cursor_addr;
                ram_req.wdata = {text_color, in_char_code};
                wrap          = (col_r == COL_LAST);
              end
              if (wrap) begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  // stay on the last row and shift the screen up
                  res_scroll_nxt = 1'b1;
                  rd_ptr_nxt     = PTR_COLS;
                  copy_pend_nxt  = 1'b0;
                  state_nxt      = ttw_pkg::ST_SCROLL;
                end else begin
                  row_nxt   = row_r + 1'b1;
                  state_nxt = ttw_pkg::ST_DONE;
                end
              end else begin
                col_nxt   = col_r + 1'b1;
                state_nxt = ttw_pkg::ST_DONE;
              end
            end
            ttw_pkg::OP_READ: begin
              if (idx_in_range) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ttw_pkg::ADDR_W'(in_cell_index);
                state_nxt     = ttw_pkg::ST_READ;
              end else begin
                state_nxt = ttw_pkg::ST_DONE;
              end
            end
            ttw_pkg::OP_CLEAR: begin
              row_nxt      = '0;
              col_nxt      = '0;
              fill_ptr_nxt = '0;
              state_nxt    = ttw_pkg::ST_FILL;
            end
            ttw_pkg::OP_NONE: begin
              state_nxt = ttw_pkg::ST_DONE;
            end
            default: begin
              state_nxt = ttw_pkg::ST_DONE;
            end
          endcase
        end
      end

      ttw_pkg::ST_READ: begin
        res_word_nxt = ram_rdata;
        state_nxt    = ttw_pkg::ST_DONE;
      end

      ttw_pkg::ST_SCROLL: begin
        // write back the cell read last cycle one row higher
        if (copy_pend_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = copy_wa_r;
          ram_req.wdata = ram_rdata;
        end
        if (rd_ptr_r < PTR_CELLS) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_ptr_r[ttw_pkg::ADDR_W-1:0];
          copy_wa_nxt   = ttw_pkg::ADDR_W'(rd_ptr_r - PTR_COLS);
          copy_pend_nxt = 1'b1;
          rd_ptr_nxt    = rd_ptr_r + 1'b1;
        end else begin
          copy_pend_nxt = 1'b0;
          if (!copy_pend_r) begin
            fill_ptr_nxt = LAST_ROW_BASE;
            state_nxt    = ttw_pkg::ST_FILL;
          end
        end
      end

      ttw_pkg::ST_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = fill_ptr_r;
        ram_req.wdata = {text_color, ttw_pkg::BLANK_CHAR};
        fill_ptr_nxt  = fill_ptr_r + 1'b1;
        if (fill_ptr_r == ADDR_LAST) begin
          state_nxt = ttw_pkg::ST_DONE;
        end
      end

      ttw_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ttw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ttw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      rd_ptr_r    <= '0;
      copy_pend_r <= 1'b0;
      fill_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      copy_pend_r <= copy_pend_nxt;
      fill_ptr_r  <= fill_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_wa_r    <= copy_wa_nxt;
    res_word_r   <= res_word_nxt;
    res_scroll_r <= res_scroll_nxt;
    if (out_load) begin
      out_word_r   <= res_word_r;
      out_row_r    <= ttw_pkg::ROW_OUT_W'(row_r);
      out_col_r    <= ttw_pkg::COL_OUT_W'(col_r);
      out_scroll_r <= res_scroll_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_word  = out_word_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_did_scroll = out_scroll_r;

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ROW_LAST) && (col_r <= COL_LAST))
    else $error("cursor outside the screen");

  a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttw_pkg::ST_SCROLL && copy_pend_r) |->
      (ttw_pkg::PTR_W'(copy_wa_r) < rd_ptr_r))
    else $error("scroll write-back overtook the read pointer");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttw_pkg::ST_DONE && res_scroll_r) |->
      (row_r == ROW_LAST && col_r == '0 && res_word_r == '0))
    else $error("scroll finished with a misplaced cursor");

  a_no_beat_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttw_pkg::ST_SCROLL || state_r == ttw_pkg::ST_FILL ||
     state_r == ttw_pkg::ST_INIT) |-> !out_load)
    else $error("result loaded during a screen sweep");

endmodule

@@ tb/text_terminal_checker.sv @@
// Checker for the text terminal writer: mirrors the screen and cursor, compares every result beat.
module text_terminal_checker
  import ttw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [IDX_W-1:0]      in_cell_index,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CELL_W-1:0]     out_cell_word,
  input  logic [ROW_OUT_W-1:0]  out_cursor_row,
  input  logic [COL_OUT_W-1:0]  out_cursor_col,
  input  logic                  out_did_scroll,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    mismatch_count,
  output int                    reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CELL_W-1:0]    word;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 scrolled;
  } cursor_report_t;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [ATTR_W-1:0] attr_reg;
  int unsigned       cur_row;
  int unsigned       cur_col;
  cursor_report_t    predicted_reports [$];

  function automatic void blank_from(int unsigned first_cell);
    for (int unsigned i = first_cell; i < CELL_COUNT; i++) begin
      screen[i] = {attr_reg, BLANK_CHAR};
    end
  endfunction

  // Go to the start of the next row; scroll when already on the last one.
  function automatic logic line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      cur_row = ROWS - 1;
      for (int unsigned i = 0; i < CELL_COUNT - COLUMNS; i++) begin
        screen[i] = screen[i + COLUMNS];
      end
      blank_from(CELL_COUNT - COLUMNS);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cursor_report_t run_command(op_t op, logic [CHAR_W-1:0] ch,
                                                 logic [IDX_W-1:0] idx);
    cursor_report_t rep;
    int unsigned    pos;
    rep = '0;
    case (op)
      OP_PUT: begin
        if (ch == NEWLINE_CODE) begin
          rep.scrolled = line_feed();
        end else begin
          pos = cur_row * COLUMNS + cur_col;
          screen[pos] = {attr_reg, ch};
          cur_col++;
          if (cur_col >= COLUMNS) rep.scrolled = line_feed();
        end
      end
      OP_READ: begin
        if (idx < CELL_COUNT) rep.word = screen[idx];
      end
      OP_CLEAR: begin
        blank_from(0);
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    rep.row = ROW_OUT_W'(cur_row);
    rep.col = COL_OUT_W'(cur_col);
    return rep;
  endfunction

  initial begin
    mismatch_count = 0;
    reports_due    = 0;
    attr_reg       = RESET_ATTR;
    cur_row        = 0;
    cur_col        = 0;
    blank_from(0);
  end

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == CFG_TEXT_COLOR) begin
        attr_reg = pwdata[ATTR_W-1:0];
      end
      if (out_valid && out_ready) begin
        got = {out_cell_word, out_cursor_row, out_cursor_col, out_did_scroll};
        if (predicted_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result beat with nothing outstanding: word %h row %0d col %0d scroll %0b",
                     $realtime, got.word, got.row, got.col, got.scrolled);
          end
        end else begin
          want = predicted_reports.pop_front();
          if (got.word !== want.word || got.row !== want.row ||
              got.col !== want.col || got.scrolled !== want.scrolled) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected word %h row %0d col %0d scroll %0b, got word %h row %0d col %0d scroll %0b",
                       $realtime, want.word, want.row, want.col, want.scrolled,
                       got.word, got.row, got.col, got.scrolled);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted_reports.push_back(run_command(op_t'(in_opcode), in_char_code, in_cell_index));
      end
      reports_due = predicted_reports.size();
    end
  end

endmodule

@@ tb/text_terminal_writer_unit_test.sv @@
// Top of the text terminal writer testbench: clock, reset, stimulus, color writes and verdict.
module text_terminal_writer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ttw_pkg::*;

  localparam int RX_HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   in_opcode;
  logic [CHAR_W-1:0]     in_char_code;
  logic [IDX_W-1:0]      in_cell_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [CELL_W-1:0]     out_cell_word;
  logic [ROW_OUT_W-1:0]  out_cursor_row;
  logic [COL_OUT_W-1:0]  out_cursor_col;
  logic                  out_did_scroll;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatch_count;
  int                    reports_due;

  bit steady  = 1'b0;
  bit hold_rx = 1'b0;

  always #4 clk = ~clk;

  text_terminal_writer_unit u_dut (.*);

  text_terminal_checker u_checker (.*);

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random back-pressure, or a long hold when asked.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end else begin
        out_ready = steady || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  task automatic set_text_color(input logic [ATTR_W-1:0] attr);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {CFG_TEXT_COLOR, 2'b00};
    pwdata  = {(CFG_DATA_W - ATTR_W)'($urandom), attr};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic offer(input op_t op, input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_opcode     = op;
    in_char_code  = ch;
    in_cell_index = idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (reports_due != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int nl_pct);
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    int unsigned       pick;
    repeat (count) begin
      pick = $urandom_range(0, 999);
      ch   = CHAR_W'($urandom_range(0, 255));
      idx  = IDX_W'($urandom_range(0, 2047));
      if (pick < 4) begin
        op = OP_CLEAR;
      end else if (pick < 34) begin
        op = OP_NONE;
      end else if (pick < 254) begin
        op = OP_READ;
        // Bias reads toward the top rows, the bottom rows and past the end.
        case ($urandom_range(0, 5))
          0: idx = IDX_W'($urandom_range(0, 2 * COLUMNS - 1));
          1: idx = IDX_W'($urandom_range(CELL_COUNT - 2 * COLUMNS, CELL_COUNT - 1));
          2: idx = IDX_W'($urandom_range(CELL_COUNT, 2047));
          3, 4: idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
          default: ;
        endcase
      end else begin
        op = OP_PUT;
        if ($urandom_range(0, 99) < nl_pct) ch = NEWLINE_CODE;
      end
      offer(op, ch, idx);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_PUT;
    in_char_code  = '0;
    in_cell_index = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    set_text_color(8'hA5);
    offer(OP_PUT, 8'h00, 11'd0);
    offer(OP_PUT, 8'hFF, 11'h7FF);
    offer(OP_PUT, 8'h41, 11'd0);
    offer(OP_PUT, NEWLINE_CODE, 11'd0);
    offer(OP_PUT, 8'h0B, 11'd0);
    offer(OP_READ, 8'h00, 11'd0);
    offer(OP_READ, 8'h00, 11'd1);
    offer(OP_READ, 8'h00, 11'd2);
    offer(OP_READ, 8'h00, 11'd3);
    offer(OP_READ, 8'h00, 11'd80);
    offer(OP_READ, 8'hFF, 11'd1999);
    offer(OP_READ, 8'h00, 11'd2000);
    offer(OP_READ, 8'h00, 11'h7FF);
    offer(OP_NONE, 8'hFF, 11'h7FF);
    offer(OP_CLEAR, NEWLINE_CODE, 11'h555);
    offer(OP_READ, 8'h00, 11'd0);
    offer(OP_READ, 8'h00, 11'd80);
    offer(OP_READ, 8'h00, 11'd1999);
    offer(OP_PUT, 8'h7F, 11'd0);
    offer(OP_READ, 8'h00, 11'd0);
    offer(OP_READ, 8'h00, 11'd1);

    drain();
    set_text_color(8'hFF);
    run_phase(270, 12);

    // Mostly long lines so that puts wrap; hold the result side mid-phase.
    drain();
    set_text_color(8'h00);
    run_phase(60, 1);
    hold_rx = 1'b1;
    run_phase(210, 1);

    drain();
    set_text_color(ATTR_W'($urandom_range(1, 254)));
    run_phase(130, 6);
    drain();
    run_phase(140, 6);

    drain();
    set_text_color(ATTR_W'($urandom_range(0, 255)));
    steady = 1'b1;
    run_phase(150, 2);
    steady = 1'b0;
    run_phase(120, 2);

    drain();
    repeat (50) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
